// ===== hw/rtl/svpwm_pkg.sv =====
// Shared types, codes and helper functions for the space vector PWM duty generator.
// No dependencies; the other files in hw/rtl that use it refer to it by scoped names.
package svpwm_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_BUS     = 1'd1;

  localparam logic [15:0] PWM_PERIOD_RST = 16'd4250;
  localparam logic [15:0] DC_BUS_RST     = 16'd24000;

  // sqrt(3) with 24 fraction bits, rounded to nearest at the working precision at elaboration.
  localparam longint SQRT3_Q24 = 64'd29058991;

  // Width of the signed compare values v1, v2 and v3.
  localparam int VAL_W = 35;

  // Sector codes.
  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;

  // Control that travels alongside the data through the divider and back end.
  typedef struct packed {
    logic [2:0] sec;
    logic       ovm;
    logic       neg1;
    logic       neg2;
  } side_t;

  // Map of the three projection signs onto the sector number.
  function automatic logic [2:0] sector_of(input logic [2:0] idx);
    logic [2:0] s;
    case (idx)
      3'd1:    s = SEC_2;
      3'd2:    s = SEC_6;
      3'd3:    s = SEC_1;
      3'd4:    s = SEC_4;
      3'd5:    s = SEC_3;
      3'd6:    s = SEC_5;
      default: s = SEC_ZERO;
    endcase
    return s;
  endfunction

  // Saturate a signed compare value to the 15-bit timer range.
  function automatic logic [14:0] clamp15(input logic signed [VAL_W-1:0] v);
    logic [14:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > VAL_W'(32767)) begin
      r = 15'h7fff;
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/svpwm_in_if.sv =====
// Input channel carrying one alpha/beta voltage vector per transfer.
// Standalone; used by the top level and the testbench.
interface svpwm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] volt_alpha;
  logic signed [15:0] volt_beta;

  modport source (output valid, volt_alpha, volt_beta, input ready);
  modport sink   (input valid, volt_alpha, volt_beta, output ready);
endinterface

// ===== hw/rtl/svpwm_out_if.sv =====
// Output channel carrying three phase compare values, the sector and the flag.
// Standalone; used by the top level and the testbench.
interface svpwm_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] duty_a;
  logic [14:0] duty_b;
  logic [14:0] duty_c;
  logic [2:0]  sector_num;
  logic        over_modulated;

  modport source (output valid, duty_a, duty_b, duty_c, sector_num, over_modulated,
                  input ready);
  modport sink   (input valid, duty_a, duty_b, duty_c, sector_num, over_modulated,
                  output ready);
endinterface

// ===== hw/rtl/svpwm_cfg_if.sv =====
// Configuration write channel: register index and write data per transfer.
// Depends on svpwm_pkg for the index width.
interface svpwm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [svpwm_pkg::CFG_IDX_W-1:0]   index;
  logic [15:0]                       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/svpwm_duty_generator_unit.sv =====
// Top level of the seven-segment space vector PWM duty generator.
// Depends on svpwm_pkg, the three channel interfaces, svpwm_front, svpwm_div_pipe, svpwm_back.
//
//   Channel | Direction | Transfer carries
//   --------+-----------+---------------------------------------------------------
//   vin     | in        | volt_alpha, volt_beta (signed 16-bit, millivolts)
//   dout    | out       | duty_a, duty_b, duty_c, sector_num, over_modulated
//   cfg     | in        | index (0 = pwm_period, 1 = dc_bus_voltage), data
//
// One vector can be accepted every clock cycle while dout is not stalled. An input transfer
// reaches dout through five front stages, FRAC_BITS + 33
// divider stages (one quotient bit each) and four back-end stages including the output
// register. The long division of the active times sets that depth.
// Reset clears every valid bit and loads the period and bus voltage defaults.
// When dout holds a result that is not taken, the whole pipeline halts and nothing is
// lost or repeated; vin.ready follows that condition.
module svpwm_duty_generator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  svpwm_in_if.sink    vin,
  svpwm_out_if.source dout,
  svpwm_cfg_if.sink   cfg
);
  localparam int NW = 2 * FRAC_BITS + 34;
  localparam int DW = FRAC_BITS + 19;
  localparam int QW = FRAC_BITS + 33;

  // Configuration registers. The user must write them only while the pipeline is empty;
  // the block itself does not enforce this. The stages read them directly.
  logic [15:0] pwm_period;
  logic [15:0] dc_bus_voltage;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period     <= svpwm_pkg::PWM_PERIOD_RST;
      dc_bus_voltage <= svpwm_pkg::DC_BUS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        svpwm_pkg::CFG_PWM_PERIOD: pwm_period     <= cfg.data;
        svpwm_pkg::CFG_DC_BUS:     dc_bus_voltage <= cfg.data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being emptied.
  logic en;
  assign en        = !dout.valid || dout.ready;
  assign vin.ready = en;

  logic             fr_valid;
  svpwm_pkg::side_t fr_side;
  logic [NW-1:0]    fr_num1, fr_num2;
  logic [DW-1:0]    fr_den;

  svpwm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (vin.valid),
    .volt_alpha     (vin.volt_alpha),
    .volt_beta      (vin.volt_beta),
    .pwm_period     (pwm_period),
    .dc_bus_voltage (dc_bus_voltage),
    .out_valid      (fr_valid),
    .out_side       (fr_side),
    .num1           (fr_num1),
    .num2           (fr_num2),
    .den            (fr_den)
  );

  logic             dv_valid;
  svpwm_pkg::side_t dv_side;
  logic [QW-1:0]    dv_quo1, dv_quo2;

  // Active times: |n| * T / (2V) normally, |n| * T * 2^F / (n1 + n2) when scaled.
  svpwm_div_pipe #(.NW(NW), .DW(DW), .QW(QW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .num1      (fr_num1),
    .num2      (fr_num2),
    .den       (fr_den),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .quo1      (dv_quo1),
    .quo2      (dv_quo2)
  );

  svpwm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (dv_valid),
    .in_side        (dv_side),
    .quo1           (dv_quo1),
    .quo2           (dv_quo2),
    .pwm_period     (pwm_period),
    .out_valid      (dout.valid),
    .duty_a         (dout.duty_a),
    .duty_b         (dout.duty_b),
    .duty_c         (dout.duty_c),
    .sector_num     (dout.sector_num),
    .over_modulated (dout.over_modulated)
  );

endmodule

// ===== hw/rtl/svpwm_front.sv =====
// Front end: sector detection, X/Y/Z numerators, over-modulation test and dividend forming.
// Depends on svpwm_pkg.
module svpwm_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [15:0]            volt_alpha,
  input  logic signed [15:0]            volt_beta,
  input  logic [15:0]                   pwm_period,
  input  logic [15:0]                   dc_bus_voltage,
  output logic                          out_valid,
  output svpwm_pkg::side_t              out_side,
  output logic [2*FRAC_BITS+33:0]       num1,
  output logic [2*FRAC_BITS+33:0]       num2,
  output logic [FRAC_BITS+18:0]         den
);
  localparam int F    = FRAC_BITS;
  localparam int PW   = F + 18;   // signed products with sqrt(3)
  localparam int NBW  = F + 19;   // signed numerators
  localparam int MW   = F + 18;   // numerator magnitudes
  localparam int DW   = F + 19;   // divisor
  localparam int PRW  = MW + 16;  // magnitude times period
  localparam int NW   = PRW + F;  // dividend
  localparam int S3W  = F + 2;
  localparam longint S3_VAL =
    (svpwm_pkg::SQRT3_Q24 + ((64'd1 << (24 - F)) >> 1)) >> (24 - F);
  localparam logic signed [S3W-1:0] S3 = S3W'(S3_VAL);

  logic [15:0] bus_v;
  assign bus_v = (dc_bus_voltage == 16'd0) ? 16'd1 : dc_bus_voltage;

  // Stage 1: input register.
  logic               v1;
  logic signed [15:0] a1, b1;
  // Stage 2: products with sqrt(3).
  logic               v2;
  logic signed [15:0] a2, b2;
  logic signed [PW-1:0] pa2, pb2;
  // Stage 3: sector and selected numerators.
  logic                  v3;
  logic [2:0]            sec3;
  logic signed [NBW-1:0] n1_3, n2_3;
  // Stage 4: magnitudes and over-modulation decision.
  logic                  v4;
  logic [2:0]            sec4;
  logic [MW-1:0]         mag1_4, mag2_4;
  logic                  neg1_4, neg2_4, ovm4;
  logic [DW-1:0]         sum4;
  // Stage 5: products with the period and the divisor.
  logic [PRW-1:0]        prod1, prod2;

  // Stage 3 logic.
  logic signed [NBW-1:0] pa_e, pb_e, bf, af, a3f, xn, yn, zn, n1_c, n2_c;
  logic [2:0]            idx, sec_c;
  always_comb begin
    pa_e = NBW'(pa2);
    pb_e = NBW'(pb2);
    bf   = NBW'(b2) <<< F;
    af   = NBW'(a2) <<< F;
    a3f  = (af <<< 1) + af;
    idx[0] = (b2 > 16'sd0);
    idx[1] = ((pa_e - bf) > 0);
    idx[2] = ((-pa_e - bf) > 0);
    sec_c  = svpwm_pkg::sector_of(idx);
    xn = pb_e <<< 1;
    yn = a3f + pb_e;
    zn = pb_e - a3f;
    case (sec_c)
      svpwm_pkg::SEC_1: begin n1_c = -zn; n2_c = xn;  end
      svpwm_pkg::SEC_2: begin n1_c = zn;  n2_c = yn;  end
      svpwm_pkg::SEC_3: begin n1_c = xn;  n2_c = -yn; end
      svpwm_pkg::SEC_4: begin n1_c = -xn; n2_c = zn;  end
      svpwm_pkg::SEC_5: begin n1_c = -yn; n2_c = -zn; end
      svpwm_pkg::SEC_6: begin n1_c = yn;  n2_c = -xn; end
      default:          begin n1_c = '0;  n2_c = '0;  end
    endcase
  end

  // Stage 4 logic.
  logic signed [NBW:0] sum_c, lim_c;
  logic                ovm_c;
  logic signed [NBW-1:0] abs1_c, abs2_c;
  always_comb begin
    sum_c  = (NBW+1)'(n1_3) + (NBW+1)'(n2_3);
    lim_c  = $signed((NBW+1)'(bus_v)) <<< (F + 1);
    ovm_c  = (sec3 != svpwm_pkg::SEC_ZERO) && (pwm_period != 16'd0) && (sum_c > lim_c);
    abs1_c = n1_3[NBW-1] ? -n1_3 : n1_3;
    abs2_c = n2_3[NBW-1] ? -n2_3 : n2_3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1     <= volt_alpha;
      b1     <= volt_beta;
      a2     <= a1;
      b2     <= b1;
      pa2    <= PW'(S3) * PW'(a1);
      pb2    <= PW'(S3) * PW'(b1);
      sec3   <= sec_c;
      n1_3   <= n1_c;
      n2_3   <= n2_c;
      sec4   <= sec3;
      mag1_4 <= abs1_c[MW-1:0];
      mag2_4 <= abs2_c[MW-1:0];
      neg1_4 <= n1_3[NBW-1];
      neg2_4 <= n2_3[NBW-1];
      ovm4   <= ovm_c;
      sum4   <= sum_c[DW-1:0];
      prod1  <= PRW'(mag1_4) * PRW'(pwm_period);
      prod2  <= PRW'(mag2_4) * PRW'(pwm_period);
      den    <= ovm4 ? sum4 : DW'({bus_v, 1'b0});
      out_side.sec  <= sec4;
      out_side.ovm  <= ovm4;
      out_side.neg1 <= neg1_4;
      out_side.neg2 <= neg2_4;
    end
  end

  // When scaled, the dividend carries the extra 2^F of the period term.
  assign num1 = out_side.ovm ? {prod1, {F{1'b0}}} : NW'(prod1);
  assign num2 = out_side.ovm ? {prod2, {F{1'b0}}} : NW'(prod2);

endmodule

// ===== hw/rtl/svpwm_div_pipe.sv =====
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// Depends on svpwm_pkg for the sideband type.
module svpwm_div_pipe #(
  parameter int NW = 66,
  parameter int DW = 35,
  parameter int QW = 49
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  svpwm_pkg::side_t in_side,
  input  logic [NW-1:0]    num1,
  input  logic [NW-1:0]    num2,
  input  logic [DW-1:0]    den,
  output logic             out_valid,
  output svpwm_pkg::side_t out_side,
  output logic [QW-1:0]    quo1,
  output logic [QW-1:0]    quo2
);
  // One long division step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] r, input logic [QW-1:0] w,
                                                input logic [DW-1:0] d);
    logic [DW:0]   t;
    logic          ge;
    logic [DW-1:0] rn;
    t  = {r, w[QW-1]};
    ge = (t >= {1'b0, d});
    rn = ge ? DW'(t - {1'b0, d}) : t[DW-1:0];
    return {rn, w[QW-2:0], ge};
  endfunction

  logic [DW-1:0]    rem1 [QW];
  logic [DW-1:0]    rem2 [QW];
  logic [QW-1:0]    wrk1 [QW];
  logic [QW-1:0]    wrk2 [QW];
  logic [DW-1:0]    dsr  [QW];
  svpwm_pkg::side_t sd   [QW];
  logic             vld  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0]    r1_i, r2_i, d_i;
    logic [QW-1:0]    w1_i, w2_i;
    svpwm_pkg::side_t s_i;
    logic             v_i;
    if (k == 0) begin : g_first
      assign r1_i = DW'(num1[NW-1:QW]);
      assign r2_i = DW'(num2[NW-1:QW]);
      assign w1_i = num1[QW-1:0];
      assign w2_i = num2[QW-1:0];
      assign d_i  = den;
      assign s_i  = in_side;
      assign v_i  = in_valid;
    end else begin : g_next
      assign r1_i = rem1[k-1];
      assign r2_i = rem2[k-1];
      assign w1_i = wrk1[k-1];
      assign w2_i = wrk2[k-1];
      assign d_i  = dsr[k-1];
      assign s_i  = sd[k-1];
      assign v_i  = vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        {rem1[k], wrk1[k]} <= div_step(r1_i, w1_i, d_i);
        {rem2[k], wrk2[k]} <= div_step(r2_i, w2_i, d_i);
        dsr[k] <= d_i;
        sd[k]  <= s_i;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_side  = sd[QW-1];
  assign quo1      = wrk1[QW-1];
  assign quo2      = wrk2[QW-1];

endmodule

// ===== hw/rtl/svpwm_back.sv =====
// Back end: signed active times, compare values v1..v3, phase routing and output register.
// Depends on svpwm_pkg.
module svpwm_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  svpwm_pkg::side_t         in_side,
  input  logic [FRAC_BITS+32:0]    quo1,
  input  logic [FRAC_BITS+32:0]    quo2,
  input  logic [15:0]              pwm_period,
  output logic                     out_valid,
  output logic [14:0]              duty_a,
  output logic [14:0]              duty_b,
  output logic [14:0]              duty_c,
  output logic [2:0]               sector_num,
  output logic                     over_modulated
);
  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 33;
  localparam int TW  = QW + 1;
  localparam int DFW = F + 36;
  localparam int VW  = svpwm_pkg::VAL_W;

  // Signed shift right by k that truncates toward zero.
  function automatic logic signed [DFW-1:0] trunc_shr(input logic signed [DFW-1:0] x,
                                                      input int k);
    logic signed [DFW-1:0] bias;
    bias = x[DFW-1] ? $signed((DFW'(1) << k) - DFW'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

  logic                  b1_v, b2_v, b3_v;
  svpwm_pkg::side_t      b1_s, b2_s, b3_s;
  logic signed [TW-1:0]  b1_t1, b1_t2, b2_t2;
  logic signed [VW-1:0]  b1_v1, b2_v1, b2_v2, b3_v1, b3_v2, b3_v3;

  logic signed [TW-1:0]  t1_c, t2_c;
  logic signed [DFW-1:0] diff_c, x2_c, x3_c, q1_c, q2_c, q3_c;
  always_comb begin
    t1_c   = in_side.neg1 ? -$signed({1'b0, quo1}) : $signed({1'b0, quo1});
    t2_c   = in_side.neg2 ? -$signed({1'b0, quo2}) : $signed({1'b0, quo2});
    diff_c = $signed(DFW'(pwm_period) << F) - DFW'(t1_c) - DFW'(t2_c);
    q1_c   = trunc_shr(diff_c, F + 2);
    x2_c   = (DFW'(b1_v1) <<< (F + 1)) + DFW'(b1_t1);
    q2_c   = trunc_shr(x2_c, F + 1);
    x3_c   = (DFW'(b2_v2) <<< (F + 1)) + DFW'(b2_t2);
    q3_c   = trunc_shr(x3_c, F + 1);
  end

  logic signed [VW-1:0] pa_c, pb_c, pc_c;
  always_comb begin
    case (b3_s.sec)
      svpwm_pkg::SEC_1: begin pa_c = b3_v1; pb_c = b3_v2; pc_c = b3_v3; end
      svpwm_pkg::SEC_2: begin pa_c = b3_v2; pb_c = b3_v1; pc_c = b3_v3; end
      svpwm_pkg::SEC_3: begin pa_c = b3_v3; pb_c = b3_v1; pc_c = b3_v2; end
      svpwm_pkg::SEC_4: begin pa_c = b3_v3; pb_c = b3_v2; pc_c = b3_v1; end
      svpwm_pkg::SEC_5: begin pa_c = b3_v2; pb_c = b3_v3; pc_c = b3_v1; end
      svpwm_pkg::SEC_6: begin pa_c = b3_v1; pb_c = b3_v3; pc_c = b3_v2; end
      default: begin
        pa_c = VW'(pwm_period[15:2]);
        pb_c = VW'(pwm_period[15:2]);
        pc_c = VW'(pwm_period[15:2]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_v <= in_valid;
      b2_v <= b1_v;
      b3_v <= b2_v;
      out_valid <= b3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_s  <= in_side;
      b1_t1 <= t1_c;
      b1_t2 <= t2_c;
      b1_v1 <= q1_c[VW-1:0];
      b2_s  <= b1_s;
      b2_t2 <= b1_t2;
      b2_v1 <= b1_v1;
      b2_v2 <= q2_c[VW-1:0];
      b3_s  <= b2_s;
      b3_v1 <= b2_v1;
      b3_v2 <= b2_v2;
      b3_v3 <= q3_c[VW-1:0];
      duty_a         <= svpwm_pkg::clamp15(pa_c);
      duty_b         <= svpwm_pkg::clamp15(pb_c);
      duty_c         <= svpwm_pkg::clamp15(pc_c);
      sector_num     <= b3_s.sec;
      over_modulated <= b3_s.ovm;
    end
  end

endmodule

// ===== hw/rtl/svpwm_checker.sv =====
// Port-level checks for svpwm_duty_generator_unit and the bind that attaches them.
// Depends only on the top level's channel signals.
module svpwm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] duty_a,
  input logic [14:0] duty_b,
  input logic [14:0] duty_c,
  input logic [2:0]  sector_num,
  input logic        over_modulated
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(duty_a) && $stable(duty_b) && $stable(duty_c)
                                   && $stable(sector_num)))
    else $error("stalled result changed");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector_num <= 3'd6))
    else $error("sector out of range");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sector_num == 3'd0) |-> (!over_modulated && duty_a == duty_b
                                          && duty_b == duty_c))
    else $error("zero vector result inconsistent");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused with empty output");
endmodule

bind svpwm_duty_generator_unit svpwm_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (vin.ready),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .duty_a         (dout.duty_a),
  .duty_b         (dout.duty_b),
  .duty_c         (dout.duty_c),
  .sector_num     (dout.sector_num),
  .over_modulated (dout.over_modulated)
);

// ===== tb/tb_svpwm_duty_generator_unit.sv =====
// Self-checking testbench for the space vector PWM duty generator top level.
// Depends on svpwm_pkg, the three channel interfaces and svpwm_duty_generator_unit.
`timescale 1ns / 1ps

module tb_svpwm_duty_generator_unit;

  localparam int FRAC_BITS   = 16;
  localparam int LATENCY     = FRAC_BITS + 42;
  localparam int IDLE_PCT    = 7;
  localparam int RAND_PHASES = 8;
  localparam int PER_PHASE   = 185;

  // One expected set of compare values, sector and flag.
  typedef struct {
    logic [14:0] duty_a;
    logic [14:0] duty_b;
    logic [14:0] duty_c;
    logic [2:0]  sector;
    logic        ovm;
  } duty_set_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    bit                 typed;
    duty_set_t          want;
  } vec_row_t;

  logic clk;
  logic rst;

  svpwm_in_if  vin();
  svpwm_out_if dout();
  svpwm_cfg_if cfg();

  svpwm_duty_generator_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin),
    .dout (dout),
    .cfg  (cfg)
  );

  // Shadow copy of the two registers, updated on each configuration transfer.
  logic [15:0] period_reg;
  logic [15:0] bus_reg;

  duty_set_t pending_duties[$];
  int        errors;
  int        sent_count;
  int        result_count;
  int        ovm_count;
  int        sector_hits[7];
  bit        calm;

  // Clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A generous ceiling on the whole run; a correct run finishes far sooner.
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Truncating scale of a signed numerator by m / d, with a wide intermediate
  // product so that period * 2^F times a full-scale numerator cannot overflow.
  function automatic longint scale_trunc(input longint n, input logic [127:0] m,
                                         input logic [127:0] d);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    q   = (mag * m) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [14:0] sat15(input longint v);
    if (v < 0) return '0;
    if (v > 32767) return 15'h7fff;
    return v[14:0];
  endfunction

  // Works out the compare values for one vector under the current registers.
  function automatic duty_set_t predict_duties(input logic signed [15:0] alpha,
                                               input logic signed [15:0] beta);
    duty_set_t  r;
    longint     one_f, one_f1, s3, a, b, tp, vb;
    longint     xn, yn, zn, n1, n2, t1, t2, v1, v2, v3;
    longint     d0, d1, d2;
    logic [2:0] signs;
    logic [2:0] sec;
    one_f  = longint'(1) << FRAC_BITS;
    one_f1 = longint'(1) << (FRAC_BITS + 1);
    s3     = (svpwm_pkg::SQRT3_Q24 + ((longint'(1) << (24 - FRAC_BITS)) >>> 1))
             >>> (24 - FRAC_BITS);
    a      = alpha;
    b      = beta;
    tp     = period_reg;
    vb     = (bus_reg == 0) ? 1 : bus_reg;
    n1     = 0;
    n2     = 0;
    r.ovm  = 1'b0;

    // Sector from the signs of the three projections.
    signs[0] = (b > 0);
    signs[1] = (s3 * a - b * one_f > 0);
    signs[2] = (-s3 * a - b * one_f > 0);
    case (signs)
      3'd1:    sec = svpwm_pkg::SEC_2;
      3'd2:    sec = svpwm_pkg::SEC_6;
      3'd3:    sec = svpwm_pkg::SEC_1;
      3'd4:    sec = svpwm_pkg::SEC_4;
      3'd5:    sec = svpwm_pkg::SEC_3;
      3'd6:    sec = svpwm_pkg::SEC_5;
      default: sec = svpwm_pkg::SEC_ZERO;
    endcase

    if (sec == svpwm_pkg::SEC_ZERO) begin
      d0 = tp / 4;
      d1 = d0;
      d2 = d0;
    end else begin
      xn = 2 * s3 * b;
      yn = 3 * a * one_f + s3 * b;
      zn = -3 * a * one_f + s3 * b;
      case (sec)
        svpwm_pkg::SEC_1: begin n1 = -zn; n2 = xn;  end
        svpwm_pkg::SEC_2: begin n1 = zn;  n2 = yn;  end
        svpwm_pkg::SEC_3: begin n1 = xn;  n2 = -yn; end
        svpwm_pkg::SEC_4: begin n1 = -xn; n2 = zn;  end
        svpwm_pkg::SEC_5: begin n1 = -yn; n2 = -zn; end
        default:          begin n1 = yn;  n2 = -xn; end
      endcase
      if (tp != 0 && n1 + n2 > vb * one_f1) begin
        r.ovm = 1'b1;
        t1 = scale_trunc(n1, 128'(tp) << FRAC_BITS, 128'(n1 + n2));
        t2 = scale_trunc(n2, 128'(tp) << FRAC_BITS, 128'(n1 + n2));
      end else begin
        t1 = scale_trunc(n1, 128'(tp), 128'(2 * vb));
        t2 = scale_trunc(n2, 128'(tp), 128'(2 * vb));
      end
      v1 = (tp * one_f - t1 - t2) / (one_f * 4);
      v2 = (v1 * one_f1 + t1) / one_f1;
      v3 = (v2 * one_f1 + t2) / one_f1;
      case (sec)
        svpwm_pkg::SEC_1: begin d0 = v1; d1 = v2; d2 = v3; end
        svpwm_pkg::SEC_2: begin d0 = v2; d1 = v1; d2 = v3; end
        svpwm_pkg::SEC_3: begin d0 = v3; d1 = v1; d2 = v2; end
        svpwm_pkg::SEC_4: begin d0 = v3; d1 = v2; d2 = v1; end
        svpwm_pkg::SEC_5: begin d0 = v2; d1 = v3; d2 = v1; end
        default:          begin d0 = v1; d1 = v3; d2 = v2; end
      endcase
    end
    r.duty_a = sat15(d0);
    r.duty_b = sat15(d1);
    r.duty_c = sat15(d2);
    r.sector = sec;
    return r;
  endfunction

  // Drives one vector and waits for its transfer. Valid is left high so that
  // back-to-back vectors flow without a bubble; gaps are inserted at random.
  task automatic send_vector(input logic signed [15:0] alpha, input logic signed [15:0] beta,
                             input bit typed, input duty_set_t want);
    bit taken;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      vin.valid <= 1'b0;
      @(posedge clk);
    end
    vin.valid      <= 1'b1;
    vin.volt_alpha <= alpha;
    vin.volt_beta  <= beta;
    do begin
      @(negedge clk);
      taken = vin.ready;
      @(posedge clk);
    end while (!taken);
    // The expectation is computed with the registers as they stand at the transfer.
    pending_duties.push_back(typed ? want : predict_duties(alpha, beta));
    sent_count++;
  endtask

  // Writes one register. Only called when no result is outstanding.
  task automatic write_reg(input logic [svpwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    bit taken;
    vin.valid  <= 1'b0;
    cfg.valid  <= 1'b1;
    cfg.index  <= idx;
    cfg.data   <= value;
    do begin
      @(negedge clk);
      taken = cfg.ready;
      @(posedge clk);
    end while (!taken);
    cfg.valid <= 1'b0;
    if (idx == svpwm_pkg::CFG_PWM_PERIOD) period_reg = value;
    else bus_reg = value;
    @(posedge clk);
  endtask

  // Lets the pipeline drain before a register is touched or the run ends.
  task automatic drain;
    vin.valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random vectors, weighted towards sector boundaries, axes and the extremes,
  // where truncation and the sign tests are most likely to go wrong.
  task automatic random_vector(output logic signed [15:0] alpha,
                               output logic signed [15:0] beta);
    longint a, b;
    case ($urandom_range(5))
      0: begin
        a = $signed(16'($urandom));
        b = $signed(16'($urandom));
      end
      1: begin
        a = longint'($urandom_range(4000)) - 2000;
        b = longint'($urandom_range(4000)) - 2000;
      end
      2: begin
        a = longint'($urandom_range(48000)) - 24000;
        b = longint'($urandom_range(48000)) - 24000;
      end
      3: begin
        // Close to the sixty-degree line, on either side and in either half.
        a = longint'($urandom_range(36000)) - 18000;
        b = ((a * 113512) >>> 16) + longint'($urandom_range(4)) - 2;
        if ($urandom_range(1)) b = -b;
      end
      4: begin
        a = $urandom_range(1) ? 0 : longint'($signed(16'($urandom)));
        b = (a == 0) ? longint'($signed(16'($urandom)))
                     : longint'($urandom_range(2)) - 1;
      end
      default: begin
        a = $urandom_range(1) ? 32767 : -32768;
        b = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 32767 : -32768);
        if ($urandom_range(1)) begin
          a = b;
          b = $urandom_range(1) ? 1 : -1;
        end
      end
    endcase
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    if (b < -32768) b = -32768;
    alpha = a[15:0];
    beta  = b[15:0];
  endtask

  // The result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Outputs and ready are stable by the falling edge, so a transfer at the next
  // rising edge is decided here and checked against the oldest expectation.
  always @(negedge clk) begin
    duty_set_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (pending_duties.size() == 0) begin
        $error("result transfer with no vector outstanding");
        errors++;
      end else begin
        want = pending_duties.pop_front();
        result_count++;
        if (dout.over_modulated) ovm_count++;
        if (dout.sector_num <= 6) sector_hits[dout.sector_num]++;
        if (dout.duty_a !== want.duty_a) begin
          $error("duty_a expected %0d actual %0d", want.duty_a, dout.duty_a);
          errors++;
        end
        if (dout.duty_b !== want.duty_b) begin
          $error("duty_b expected %0d actual %0d", want.duty_b, dout.duty_b);
          errors++;
        end
        if (dout.duty_c !== want.duty_c) begin
          $error("duty_c expected %0d actual %0d", want.duty_c, dout.duty_c);
          errors++;
        end
        if (dout.sector_num !== want.sector) begin
          $error("sector_num expected %0d actual %0d", want.sector, dout.sector_num);
          errors++;
        end
        if (dout.over_modulated !== want.ovm) begin
          $error("over_modulated expected %0d actual %0d", want.ovm, dout.over_modulated);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases under several
  // register settings, including zero, one and full-scale values.
  initial begin
    vec_row_t           rows[$];
    vec_row_t           row;
    duty_set_t          none;
    duty_set_t          quarter;
    logic signed [15:0] ra;
    logic signed [15:0] rb;
    logic [15:0]        periods[RAND_PHASES];
    logic [15:0]        buses[RAND_PHASES];

    none           = '{default: '0};
    errors         = 0;
    sent_count     = 0;
    result_count   = 0;
    ovm_count      = 0;
    sector_hits    = '{default: 0};
    calm           = 1'b0;
    period_reg     = svpwm_pkg::PWM_PERIOD_RST;
    bus_reg        = svpwm_pkg::DC_BUS_RST;
    rst            = 1'b1;
    vin.valid      = 1'b0;
    vin.volt_alpha = '0;
    vin.volt_beta  = '0;
    cfg.valid      = 1'b0;
    cfg.index      = svpwm_pkg::CFG_PWM_PERIOD;
    cfg.data       = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The zero vector after reset gives a quarter of the default period everywhere.
    quarter = '{duty_a: 15'd1062, duty_b: 15'd1062, duty_c: 15'd1062,
                sector: svpwm_pkg::SEC_ZERO, ovm: 1'b0};
    rows.push_back('{16'sd0, 16'sd0, 1'b1, quarter});
    rows.push_back('{16'sd32767, 16'sd0, 1'b0, none});
    rows.push_back('{-16'sd32768, 16'sd0, 1'b0, none});
    rows.push_back('{16'sd0, 16'sd32767, 1'b0, none});
    rows.push_back('{16'sd0, -16'sd32768, 1'b0, none});
    rows.push_back('{16'sd32767, 16'sd32767, 1'b0, none});
    rows.push_back('{-16'sd32768, -16'sd32768, 1'b0, none});
    rows.push_back('{16'sd32767, -16'sd32768, 1'b0, none});
    rows.push_back('{-16'sd32768, 16'sd32767, 1'b0, none});
    rows.push_back('{16'sd1, 16'sd0, 1'b0, none});
    rows.push_back('{16'sd0, 16'sd1, 1'b0, none});
    rows.push_back('{-16'sd1, -16'sd1, 1'b0, none});
    // One vector in the middle of each sector, well inside the hexagon.
    rows.push_back('{16'sd3000, 16'sd1000, 1'b0, none});
    rows.push_back('{16'sd0, 16'sd3000, 1'b0, none});
    rows.push_back('{-16'sd3000, 16'sd1000, 1'b0, none});
    rows.push_back('{-16'sd3000, -16'sd1000, 1'b0, none});
    rows.push_back('{16'sd0, -16'sd3000, 1'b0, none});
    rows.push_back('{16'sd3000, -16'sd1000, 1'b0, none});
    // Straddling the sixty-degree line: one vector just below it and two just above it.
    rows.push_back('{16'sd10000, 16'sd17320, 1'b0, none});
    rows.push_back('{16'sd10000, 16'sd17321, 1'b0, none});
    rows.push_back('{16'sd10000, 16'sd17322, 1'b0, none});
    foreach (rows[i]) begin
      row = rows[i];
      send_vector(row.alpha, row.beta, row.typed, row.want);
    end
    drain();

    // Register settings for the random phases: defaults, extremes, zero
    // period, zero bus voltage (taken as one) and two random pairs.
    periods = '{svpwm_pkg::PWM_PERIOD_RST, 16'hffff, 16'd1, 16'd0, 16'hffff, 16'd20000,
                16'h0, 16'h0};
    buses   = '{svpwm_pkg::DC_BUS_RST, 16'd1, 16'hffff, 16'd24000, 16'hffff, 16'd0,
                16'h0, 16'h0};
    periods[6] = 16'($urandom);
    buses[6]   = 16'($urandom_range(65535, 1));
    periods[7] = 16'($urandom_range(9000, 100));
    buses[7]   = 16'($urandom_range(60000, 3000));

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(svpwm_pkg::CFG_PWM_PERIOD, periods[p]);
      write_reg(svpwm_pkg::CFG_DC_BUS, buses[p]);
      // The third phase runs with no idling on either side.
      calm = (p == 2);
      for (int k = 0; k < PER_PHASE; k++) begin
        random_vector(ra, rb);
        send_vector(ra, rb, 1'b0, none);
      end
      drain();
      calm = 1'b0;
    end

    repeat (LATENCY) @(posedge clk);
    if (pending_duties.size() != 0) begin
      $error("%0d expected results never arrived", pending_duties.size());
      errors++;
    end

    $display("Run covered %0d vectors and %0d results over %0d register settings.",
             sent_count, result_count, RAND_PHASES + 1);
    $display("Over-modulated results: %0d; per sector 0..6: %0d %0d %0d %0d %0d %0d %0d.",
             ovm_count, sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
             sector_hits[4], sector_hits[5], sector_hits[6]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_in_if.sv
hw/rtl/svpwm_out_if.sv
hw/rtl/svpwm_cfg_if.sv
hw/rtl/svpwm_front.sv
hw/rtl/svpwm_div_pipe.sv
hw/rtl/svpwm_back.sv
hw/rtl/svpwm_duty_generator_unit.sv
hw/rtl/svpwm_checker.sv
tb/tb_svpwm_duty_generator_unit.sv
